/* sv/pidaw_pkg.sv */
// shared constants, register indexes and helpers for the pid axis with integrator clamp
package pidaw_pkg;

    // default number of fractional bits
    localparam int FRAC_BITS_DEF = 16;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_UPPER   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_LOWER   = 3'd6;

    // register reset values
    localparam logic [15:0]        SAMPLE_PERIOD_RST = 16'd6554;
    localparam logic [23:0]        SAMPLE_RATE_RST   = 24'd655360;
    localparam logic [30:0]        INTEG_UPPER_RST   = 31'd327680;
    localparam logic signed [31:0] INTEG_LOWER_RST   = -32'sd327680;

    // stream widths
    localparam int IN_DATA_W  = 96;
    localparam int OUT_DATA_W = 120;
    localparam int DRIVE_W    = 18;

    // shared multiplier operand and product widths
    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 25;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // saturate a wide signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

/* sv/pid_step_antiwindup_top.sv */
// pid controller axis with clamped integrator, one shared multiplier under a sequencer
//
// One PID axis in signed fixed point with FRAC_BITS fractional bits. Each input item
// carries an error, a position and a velocity; tuser selects whether the velocity is
// derived from the position difference times the sample rate (0) or taken as given (1).
// The block takes one item at a time: an accept state, five passes through a single
// 33x25 signed multiplier (velocity, error times period, P, I and D), a drain state for the
// last product and a state that forms the clamped drive. The five products go through
// the multiplier one after another since the integral product needs the freshly clamped
// accumulator. The result sits in an output register, so a new item is taken while it
// waits. Configuration registers are written through the cfg channel, which is always
// ready; writes are meant to happen while no item is in flight.
module pid_step_antiwindup_top
    import pidaw_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // input item channel
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,  // error_in[31:0], position_in[63:32], velocity_in[95:64]
    input  logic                  s_tuser,  // vel_source
    // result channel
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata   // drive_out[17:0], p_term[49:18], i_term[81:50],
                                            // d_term[113:82], zero pad[119:114]
);

    // sequencer codes
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_VEL   = 3'd1;
    localparam logic [2:0] ST_ACC   = 3'd2;
    localparam logic [2:0] ST_PROP  = 3'd3;
    localparam logic [2:0] ST_INTEG = 3'd4;
    localparam logic [2:0] ST_DERIV = 3'd5;
    localparam logic [2:0] ST_FIN   = 3'd6;
    localparam logic [2:0] ST_DRV   = 3'd7;

    localparam int SCL_W = PROD_W + 1;
    localparam int ACC_W = 35;
    localparam int DRV_SUM_W = 34;
    localparam logic signed [SCL_W-1:0] ROUND_HALF = SCL_W'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [DRV_SUM_W-1:0] ONE_VAL = DRV_SUM_W'(1) <<< FRAC_BITS;

    logic [2:0] state_reg, state_next;

    // configuration registers
    logic [23:0]        prop_gain_reg;
    logic [23:0]        integ_gain_reg;
    logic [23:0]        deriv_gain_reg;
    logic [15:0]        sample_period_reg;
    logic [23:0]        sample_rate_reg;
    logic [30:0]        integ_upper_reg;
    logic signed [31:0] integ_lower_reg;

    // item state and working registers
    logic signed [31:0] acc_reg;
    logic signed [31:0] prev_pos_reg;
    logic signed [31:0] err_reg;
    logic signed [31:0] pos_reg;
    logic signed [31:0] vel_in_reg;
    logic               src_reg;
    logic signed [31:0] vel_reg;
    logic signed [31:0] p_reg;
    logic signed [31:0] i_reg;
    logic signed [31:0] d_reg;

    // shared multiplier
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod_reg;

    // post-multiply scaling
    logic signed [SCL_W-1:0]   prod_rnd;
    logic signed [SCL_W-1:0]   scaled;
    logic signed [31:0]        scaled_sat;
    logic signed [ACC_W-1:0]   acc_sum;
    logic signed [ACC_W-1:0]   acc_upper;
    logic signed [ACC_W-1:0]   acc_lower;
    logic signed [ACC_W-1:0]   acc_clamped;
    logic signed [DRV_SUM_W-1:0] drive_sum;
    logic signed [DRV_SUM_W-1:0] drive_clamped;

    // output register
    logic                  m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;
    logic                  out_free;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign out_free  = !m_tvalid_reg || m_tready;

    // multiplier operand selection per step
    always_comb begin
        unique case (state_reg)
            ST_VEL: begin
                mul_a = MUL_A_W'(pos_reg) - MUL_A_W'(prev_pos_reg);
                mul_b = {1'b0, sample_rate_reg};
            end
            ST_ACC: begin
                mul_a = MUL_A_W'(err_reg);
                mul_b = {9'd0, sample_period_reg};
            end
            ST_PROP: begin
                mul_a = MUL_A_W'(err_reg);
                mul_b = {1'b0, prop_gain_reg};
            end
            ST_INTEG: begin
                mul_a = MUL_A_W'(acc_reg);
                mul_b = {1'b0, integ_gain_reg};
            end
            ST_DERIV: begin
                mul_a = MUL_A_W'(vel_reg);
                mul_b = {1'b0, deriv_gain_reg};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // registered product
    always_ff @(posedge aclk) begin
        prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    // round to nearest, ties up, then saturate
    always_comb begin
        prod_rnd   = SCL_W'(prod_reg) + ROUND_HALF;
        scaled     = prod_rnd >>> FRAC_BITS;
        scaled_sat = sat32(64'(scaled));
    end

    // accumulator update with clamp, upper bound checked first
    always_comb begin
        acc_sum   = ACC_W'(acc_reg) + ACC_W'(scaled);
        acc_upper = ACC_W'({1'b0, integ_upper_reg});
        acc_lower = ACC_W'(integ_lower_reg);
        priority if (acc_sum > acc_upper) begin
            acc_clamped = acc_upper;
        end else if (acc_sum < acc_lower) begin
            acc_clamped = acc_lower;
        end else begin
            acc_clamped = acc_sum;
        end
    end

    // drive sum clamped to plus or minus one
    always_comb begin
        drive_sum = DRV_SUM_W'(p_reg) + DRV_SUM_W'(i_reg) - DRV_SUM_W'(d_reg);
        priority if (drive_sum > ONE_VAL) begin
            drive_clamped = ONE_VAL;
        end else if (drive_sum < -ONE_VAL) begin
            drive_clamped = -ONE_VAL;
        end else begin
            drive_clamped = drive_sum;
        end
    end

    // sequencer next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_tvalid) begin
                state_next = ST_VEL;
            end
            ST_VEL:   state_next = ST_ACC;
            ST_ACC:   state_next = ST_PROP;
            ST_PROP:  state_next = ST_INTEG;
            ST_INTEG: state_next = ST_DERIV;
            ST_DERIV: state_next = ST_FIN;
            ST_FIN:   state_next = ST_DRV;
            ST_DRV:   if (out_free) begin
                state_next = ST_IDLE;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // control state and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            m_tvalid_reg      <= 1'b0;
            prop_gain_reg     <= '0;
            integ_gain_reg    <= '0;
            deriv_gain_reg    <= '0;
            sample_period_reg <= SAMPLE_PERIOD_RST;
            sample_rate_reg   <= SAMPLE_RATE_RST;
            integ_upper_reg   <= INTEG_UPPER_RST;
            integ_lower_reg   <= INTEG_LOWER_RST;
            acc_reg           <= '0;
            prev_pos_reg      <= '0;
        end else begin
            state_reg <= state_next;

            // register writes
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_PROP_GAIN:     prop_gain_reg     <= cfg_data[23:0];
                    CFG_INTEG_GAIN:    integ_gain_reg    <= cfg_data[23:0];
                    CFG_DERIV_GAIN:    deriv_gain_reg    <= cfg_data[23:0];
                    CFG_SAMPLE_PERIOD: sample_period_reg <= cfg_data[15:0];
                    CFG_SAMPLE_RATE:   sample_rate_reg   <= cfg_data[23:0];
                    CFG_INTEG_UPPER:   integ_upper_reg   <= cfg_data[30:0];
                    CFG_INTEG_LOWER:   integ_lower_reg   <= cfg_data;
                    default: ;
                endcase
            end

            // position history in derived-velocity mode
            if (state_reg == ST_VEL && !src_reg) begin
                prev_pos_reg <= pos_reg;
            end

            // accumulator takes the clamped sum
            if (state_reg == ST_PROP) begin
                acc_reg <= sat32(64'(acc_clamped));
            end

            // result handshake
            if (state_reg == ST_DRV && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // item payload and term registers
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_tvalid) begin
            err_reg    <= s_tdata[31:0];
            pos_reg    <= s_tdata[63:32];
            vel_in_reg <= s_tdata[95:64];
            src_reg    <= s_tuser;
        end
        if (state_reg == ST_ACC) begin
            vel_reg <= src_reg ? vel_in_reg : scaled_sat;
        end
        if (state_reg == ST_INTEG) begin
            p_reg <= scaled_sat;
        end
        if (state_reg == ST_DERIV) begin
            i_reg <= scaled_sat;
        end
        if (state_reg == ST_FIN) begin
            d_reg <= scaled_sat;
        end
        if (state_reg == ST_DRV && out_free) begin
            m_tdata_reg <= {6'd0, d_reg, i_reg, p_reg, drive_clamped[DRIVE_W-1:0]};
        end
    end

endmodule
